// ===== sv/ebh_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ebh_pkg;

   localparam int NUM_BOUNDS   = 7;
   localparam int SAMPLE_WIDTH = 32;
   localparam int BOUND_REGS   = 7;
   localparam int NUM_BUCKETS  = 8;
   localparam int IDX_W        = 3;
   localparam int CNT_W        = 32;
   localparam int VAL_W        = 32;
   localparam int SUM_W        = 64;
   localparam int CSR_W        = 32;

   localparam logic [IDX_W-1:0] CSR_BOUNDS_USED = 3'd7;

   localparam logic       MODE_RECORD = 1'b0;
   localparam logic       MODE_READ   = 1'b1;

   localparam logic [CNT_W-1:0]        COUNT_MAX = '1;
   localparam logic signed [VAL_W-1:0] VAL_MAX   = {1'b0, {(VAL_W-1){1'b1}}};
   localparam logic signed [VAL_W-1:0] VAL_MIN   = {1'b1, {(VAL_W-1){1'b0}}};
   localparam logic signed [SUM_W-1:0] SUM_MAX   = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SUM_MIN   = {1'b1, {(SUM_W-1){1'b0}}};

   // classified word handed from the input stage to the accumulator
   typedef struct packed {
      logic                    mode;
      logic signed [VAL_W-1:0] sample;
      logic [IDX_W-1:0]        index;
   } item_type;

   typedef struct packed {
      logic [IDX_W-1:0]        bucket_index;
      logic [CNT_W-1:0]        bucket_count;
      logic [CNT_W-1:0]        total_count;
      logic signed [SUM_W-1:0] running_sum;
      logic signed [VAL_W-1:0] min_value;
      logic signed [VAL_W-1:0] max_value;
      logic                    has_extremes;
   } result_type;

endpackage

`default_nettype wire

// ===== sv/explicit_bucket_histogram_core.sv =====
// A word accepted on req_ reaches rsp_ through the input/classify register, then the
// accumulate/result register.
// Throughput: one word per cycle; ready only drops while the result register is stalled.
// Reset (synchronous, active high) clears boundaries, bounds_used, all counts and the sum,
// sets the min/max trackers to the most positive/negative values and empties the pipe.
`timescale 1ns / 1ps
`default_nettype none

module explicit_bucket_histogram_core (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         csr_we,
   input  wire logic [2:0]   csr_addr,
   input  wire logic [31:0]  csr_wdata,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [39:0]  req_tdata,   // sample[31:0], read_index[34:32], zero pad
   input  wire logic         req_tuser,   // mode
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [199:0]      rsp_tdata,   // bucket_index[2:0], bucket_count[34:3],
                                          // total_count[66:35], running_sum[130:67],
                                          // min_value[162:131], max_value[194:163], pad
   output logic              rsp_tuser    // has_extremes
);
   import ebh_pkg::*;

   logic       item_valid;
   logic       item_ready;
   item_type   item;
   result_type result;

   ebh_classify u_classify (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_addr       (csr_addr),
      .csr_wdata      (csr_wdata),
      .req_valid      (req_tvalid),
      .req_ready      (req_tready),
      .req_mode       (req_tuser),
      .req_sample     (req_tdata[31:0]),
      .req_read_index (req_tdata[34:32]),
      .item_valid     (item_valid),
      .item_ready     (item_ready),
      .item           (item)
   );

   ebh_accum u_accum (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item_ready (item_ready),
      .item       (item),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .result     (result)
   );

   assign rsp_tdata = {5'b0, result.max_value, result.min_value, result.running_sum,
                       result.total_count, result.bucket_count, result.bucket_index};
   assign rsp_tuser = result.has_extremes;

endmodule

`default_nettype wire

// ===== sv/ebh_classify.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ebh_classify (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_we,
   input  wire logic [ebh_pkg::IDX_W-1:0]  csr_addr,
   input  wire logic [ebh_pkg::CSR_W-1:0]  csr_wdata,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic                       req_mode,
   input  wire logic [ebh_pkg::VAL_W-1:0]  req_sample,
   input  wire logic [ebh_pkg::IDX_W-1:0]  req_read_index,
   output logic                            item_valid,
   input  wire logic                       item_ready,
   output ebh_pkg::item_type               item
);
   import ebh_pkg::*;

   logic signed [VAL_W-1:0] bound_ff [BOUND_REGS];
   logic [IDX_W-1:0]        bounds_used_ff;
   logic                    valid_ff;
   item_type                item_ff;
   item_type                item_in;
   logic [IDX_W-1:0]        used;
   logic signed [VAL_W-1:0] sample_ext;
   logic [IDX_W-1:0]        hit_idx;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < BOUND_REGS; i++) bound_ff[i] <= '0;
         bounds_used_ff <= '0;
      end else if (csr_we) begin
         if (csr_addr == CSR_BOUNDS_USED) begin
            bounds_used_ff <= csr_wdata[IDX_W-1:0];
         end else begin
            bound_ff[csr_addr] <= csr_wdata[VAL_W-1:0];
         end
      end
   end

   assign used = (bounds_used_ff > IDX_W'(NUM_BOUNDS)) ? IDX_W'(NUM_BOUNDS) : bounds_used_ff;
   assign sample_ext = VAL_W'(signed'(req_sample[SAMPLE_WIDTH-1:0]));

   // parallel compares; scan from the top so the lowest hit wins
   always_comb begin
      hit_idx = used;
      for (int i = NUM_BOUNDS - 1; i >= 0; i--) begin
         if ((IDX_W'(i) < used) && (sample_ext <= bound_ff[i])) hit_idx = IDX_W'(i);
      end
   end

   always_comb begin
      item_in.mode   = req_mode;
      item_in.sample = sample_ext;
      item_in.index  = (req_mode == MODE_READ) ? req_read_index : hit_idx;
   end

   assign req_ready = !valid_ff || item_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_ready) begin
         valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

`default_nettype wire

// ===== sv/ebh_accum.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ebh_accum (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          item_valid,
   output logic               item_ready,
   input  wire ebh_pkg::item_type item,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output ebh_pkg::result_type result
);
   import ebh_pkg::*;

   logic [CNT_W-1:0]        count_ff [NUM_BUCKETS];
   logic [CNT_W-1:0]        total_ff;
   logic signed [SUM_W-1:0] sum_ff;
   logic signed [VAL_W-1:0] smallest_ff;
   logic signed [VAL_W-1:0] largest_ff;
   logic                    seen_ff;
   logic                    rsp_valid_ff;
   result_type              result_ff;

   logic                    out_en;
   logic                    fire;
   logic                    record;
   logic [CNT_W-1:0]        count_cur;
   logic [CNT_W-1:0]        count_in;
   logic [CNT_W-1:0]        total_in;
   logic signed [SUM_W:0]   sum_wide;
   logic signed [SUM_W-1:0] sum_in;
   logic signed [VAL_W-1:0] smallest_in;
   logic signed [VAL_W-1:0] largest_in;
   result_type              result_in;

   assign out_en     = !rsp_valid_ff || rsp_ready;
   assign item_ready = out_en;
   assign fire       = item_valid && out_en;
   assign record     = fire && (item.mode == MODE_RECORD);

   assign count_cur = count_ff[item.index];
   assign count_in  = (count_cur == COUNT_MAX) ? count_cur : count_cur + 1'b1;
   assign total_in  = (total_ff == COUNT_MAX) ? total_ff : total_ff + 1'b1;

   // one guard bit catches signed overflow of the running sum
   assign sum_wide = sum_ff + item.sample;
   assign sum_in   = (sum_wide[SUM_W] != sum_wide[SUM_W-1]) ?
                     (sum_wide[SUM_W] ? SUM_MIN : SUM_MAX) : sum_wide[SUM_W-1:0];

   assign smallest_in = (item.sample < smallest_ff) ? item.sample : smallest_ff;
   assign largest_in  = (item.sample > largest_ff) ? item.sample : largest_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_BUCKETS; i++) count_ff[i] <= '0;
         total_ff    <= '0;
         sum_ff      <= '0;
         smallest_ff <= VAL_MAX;
         largest_ff  <= VAL_MIN;
         seen_ff     <= 1'b0;
      end else if (record) begin
         count_ff[item.index] <= count_in;
         total_ff    <= total_in;
         sum_ff      <= sum_in;
         smallest_ff <= smallest_in;
         largest_ff  <= largest_in;
         seen_ff     <= 1'b1;
      end
   end

   always_comb begin
      result_in.bucket_index = item.index;
      if (item.mode == MODE_RECORD) begin
         result_in.bucket_count = count_in;
         result_in.total_count  = total_in;
         result_in.running_sum  = sum_in;
         result_in.min_value    = smallest_in;
         result_in.max_value    = largest_in;
         result_in.has_extremes = 1'b1;
      end else begin
         result_in.bucket_count = count_cur;
         result_in.total_count  = total_ff;
         result_in.running_sum  = sum_ff;
         result_in.min_value    = seen_ff ? smallest_ff : '0;
         result_in.max_value    = seen_ff ? largest_ff : '0;
         result_in.has_extremes = seen_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_en) begin
         rsp_valid_ff <= item_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) result_ff <= result_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign result    = result_ff;

`ifndef SYNTHESIS
   a_empty_state: assert property (@(posedge clock) disable iff (reset)
      !seen_ff |-> (total_ff == '0) && (sum_ff == '0))
      else $error("aggregates nonzero with no sample seen");

   a_min_le_max: assert property (@(posedge clock) disable iff (reset)
      seen_ff |-> (smallest_ff <= largest_ff))
      else $error("minimum above maximum");

   a_total_monotonic: assert property (@(posedge clock) disable iff (reset)
      $past(!reset) |-> (total_ff >= $past(total_ff)))
      else $error("total count went down");

   a_stall_freezes_state: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> $stable(total_ff) && $stable(sum_ff))
      else $error("state changed while result stalled");
`endif

endmodule

`default_nettype wire
